// ===== rtl/sum_pkg.sv =====
// ----------------------------------------------------------------------------
// sum_pkg
// shared types and codes for the sorted union merge block
// ----------------------------------------------------------------------------
package sum_pkg;

    localparam int unsigned CMD_W   = 2;
    localparam int unsigned VALUE_W = 32;

    typedef logic [CMD_W-1:0]          cmd_t;
    typedef logic signed [VALUE_W-1:0] value_t;

    localparam cmd_t CMD_APPEND_FIRST  = 2'd0;
    localparam cmd_t CMD_APPEND_SECOND = 2'd1;
    localparam cmd_t CMD_MERGE         = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MERGE = 2'b10
    } state_t;

endpackage

// ===== rtl/sum_if.sv =====
// ----------------------------------------------------------------------------
// sum_in_if / sum_out_if
// valid/ready channels for command items and union results
// ----------------------------------------------------------------------------
interface sum_in_if;
    logic          valid;
    logic          ready;
    sum_pkg::cmd_t   cmd;
    sum_pkg::value_t value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface sum_out_if;
    logic            valid;
    logic            ready;
    sum_pkg::value_t value_res;
    logic            last;
    logic            empty_res;

    modport source (output valid, output value_res, output last, output empty_res,
                    input ready);
    modport sink   (input valid, input value_res, input last, input empty_res,
                    output ready);
endinterface

// ===== rtl/sorted_union_merge.sv =====
// ----------------------------------------------------------------------------
// sorted_union_merge
// union of two ascending lists of signed values, duplicates removed
// ----------------------------------------------------------------------------
// Append commands write one element per cycle into the first or second list
// memory and produce no result; an append to a full list is dropped. A merge
// command walks both memories with one read port each, one list element per
// cycle unless the result side stalls, and no new command is taken until the
// merge ends. Each distinct value is held one step before it is sent so that
// the final one can carry last; two empty lists give a single result with
// empty_res set and value_res zero. Both counts clear when the merge ends.
module sorted_union_merge #(
    parameter int unsigned LIST_DEPTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    sum_in_if.sink          items,
    sum_out_if.source       results
);

    localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    sum_pkg::value_t mem_a [LIST_DEPTH];
    sum_pkg::value_t mem_b [LIST_DEPTH];
    sum_pkg::value_t rdata_a_reg;
    sum_pkg::value_t rdata_b_reg;

    sum_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_a_reg, cnt_a_next;
    logic [CW-1:0]   cnt_b_reg, cnt_b_next;
    logic [CW-1:0]   idx_a_reg, idx_a_next;
    logic [CW-1:0]   idx_b_reg, idx_b_next;
    logic            pend_valid_reg, pend_valid_next;
    sum_pkg::value_t pend_reg, pend_next;
    logic            out_valid_reg, out_valid_next;
    sum_pkg::value_t out_value_reg, out_value_next;
    logic            out_last_reg, out_last_next;
    logic            out_empty_reg, out_empty_next;

    logic            accept;
    logic            step_ok;
    logic            more_a;
    logic            more_b;
    logic            take_a;
    sum_pkg::value_t pick;
    logic            wr_a;
    logic            wr_b;

    assign accept  = items.valid && items.ready;
    assign step_ok = !out_valid_reg || results.ready;
    assign more_a  = idx_a_reg < cnt_a_reg;
    assign more_b  = idx_b_reg < cnt_b_reg;
    assign take_a  = more_a && (!more_b || (rdata_a_reg <= rdata_b_reg));
    assign pick    = take_a ? rdata_a_reg : rdata_b_reg;
    assign wr_a    = accept && (items.cmd == sum_pkg::CMD_APPEND_FIRST)
                     && (cnt_a_reg < DEPTH_C);
    assign wr_b    = accept && (items.cmd == sum_pkg::CMD_APPEND_SECOND)
                     && (cnt_b_reg < DEPTH_C);

    assign items.ready       = (state_reg == sum_pkg::ST_IDLE);
    assign results.valid     = out_valid_reg;
    assign results.value_res = out_value_reg;
    assign results.last      = out_last_reg;
    assign results.empty_res = out_empty_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        idx_a_next      = idx_a_reg;
        idx_b_next      = idx_b_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;

        unique case (state_reg)
            sum_pkg::ST_IDLE:
            begin
                if (wr_a)
                begin
                    cnt_a_next = cnt_a_reg + CW'(1);
                end
                if (wr_b)
                begin
                    cnt_b_next = cnt_b_reg + CW'(1);
                end
                if (accept && (items.cmd == sum_pkg::CMD_MERGE))
                begin
                    idx_a_next      = '0;
                    idx_b_next      = '0;
                    pend_valid_next = 1'b0;
                    state_next      = sum_pkg::ST_MERGE;
                end
            end
            sum_pkg::ST_MERGE:
            begin
                if (step_ok)
                begin
                    if (!more_a && !more_b)
                    begin
                        // flush the held value as the final result
                        out_valid_next  = 1'b1;
                        out_value_next  = pend_valid_reg ? pend_reg : '0;
                        out_last_next   = 1'b1;
                        out_empty_next  = !pend_valid_reg;
                        pend_valid_next = 1'b0;
                        cnt_a_next      = '0;
                        cnt_b_next      = '0;
                        state_next      = sum_pkg::ST_IDLE;
                    end
                    else
                    begin
                        if (take_a)
                        begin
                            idx_a_next = idx_a_reg + CW'(1);
                        end
                        else
                        begin
                            idx_b_next = idx_b_reg + CW'(1);
                        end
                        if (!pend_valid_reg || (pick != pend_reg))
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_value_next = pend_reg;
                                out_last_next  = 1'b0;
                                out_empty_next = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_next       = pick;
                        end
                    end
                end
            end
            default:
            begin
                state_next = sum_pkg::ST_IDLE;
            end
        endcase
    end

    // list memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[cnt_a_reg[AW-1:0]] <= items.value;
        end
        if (idx_a_next < DEPTH_C)
        begin
            rdata_a_reg <= mem_a[idx_a_next[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            mem_b[cnt_b_reg[AW-1:0]] <= items.value;
        end
        if (idx_b_next < DEPTH_C)
        begin
            rdata_b_reg <= mem_b[idx_b_next[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sum_pkg::ST_IDLE;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            idx_a_reg      <= '0;
            idx_b_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            idx_a_reg      <= idx_a_next;
            idx_b_reg      <= idx_b_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg      <= pend_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_a_reg <= DEPTH_C) && (cnt_b_reg <= DEPTH_C))
        else $error("list count above depth");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sum_pkg::ST_MERGE) |->
            ((idx_a_reg <= cnt_a_reg) && (idx_b_reg <= cnt_b_reg)))
        else $error("merge index past list count");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.empty_res) |->
            (results.last && (results.value_res == '0)))
        else $error("empty result malformed");

    a_counts_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == sum_pkg::ST_MERGE) && (state_next == sum_pkg::ST_IDLE)) |=>
            ((cnt_a_reg == '0) && (cnt_b_reg == '0) && results.valid && results.last))
        else $error("merge end did not clear counts or send last");

endmodule

// ===== tb/sv/sorted_union_merge_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_union_merge_tb
// drives append, merge and unused commands with random gaps on both channels, keeps
// its own copy of both lists to work out the distinct ascending union, and
// compares every transfer on the result channel field by field
// ----------------------------------------------------------------------------
module sorted_union_merge_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIST_DEPTH   = 16;
    localparam int          RANDOM_ITEMS = 270;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          TIMEOUT_NS   = 2_000_000;

    localparam sum_pkg::cmd_t   CMD_UNUSED = 2'd3;
    localparam sum_pkg::value_t VAL_MIN    = 32'sh8000_0000;
    localparam sum_pkg::value_t VAL_MAX    = 32'sh7fff_ffff;

    typedef enum int {
        STYLE_WIDE,
        STYLE_CLUSTER,
        STYLE_EDGES
    } value_style_t;

    typedef struct packed {
        sum_pkg::cmd_t   cmd;
        sum_pkg::value_t value;
    } cmd_item_t;

    typedef struct packed {
        sum_pkg::value_t value;
        logic            last;
        logic            empty;
    } union_res_t;

    logic clk = 1'b0;
    logic rst_n;

    sum_in_if  items ();
    sum_out_if results ();

    sorted_union_merge #(
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cmd_item_t  cmd_backlog[$];
    union_res_t pending_union[$];

    sum_pkg::value_t first_mem [LIST_DEPTH];
    sum_pkg::value_t second_mem[LIST_DEPTH];
    int     first_cnt  = 0;
    int     second_cnt = 0;

    int live_items = 0;
    int mismatches = 0;

    int send_wait = 0;
    int hold_left = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;

    task automatic flag_mismatch(input string msg);
    begin
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    end
    endtask

    function automatic int draw_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 20);
    endfunction

    // list contents and counts follow every accepted command; a merge queues the expected union and clears the counts
    task automatic apply_command(input sum_pkg::cmd_t c, input sum_pkg::value_t v);
        int              i;
        int              j;
        int              emitted;
        sum_pkg::value_t pick;
        sum_pkg::value_t prev;
        union_res_t      res;
    begin
        i       = 0;
        j       = 0;
        emitted = 0;
        prev    = '0;
        case (c)
            sum_pkg::CMD_APPEND_FIRST:
            begin
                if (first_cnt < LIST_DEPTH)
                begin
                    first_mem[first_cnt] = v;
                    first_cnt++;
                end
            end
            sum_pkg::CMD_APPEND_SECOND:
            begin
                if (second_cnt < LIST_DEPTH)
                begin
                    second_mem[second_cnt] = v;
                    second_cnt++;
                end
            end
            sum_pkg::CMD_MERGE:
            begin
                while (i < first_cnt || j < second_cnt)
                begin
                    // first list wins ties
                    if (i < first_cnt && (j >= second_cnt || first_mem[i] <= second_mem[j]))
                    begin
                        pick = first_mem[i];
                        i++;
                    end
                    else
                    begin
                        pick = second_mem[j];
                        j++;
                    end
                    if (emitted == 0 || pick != prev)
                    begin
                        res.value = pick;
                        res.last  = 1'b0;
                        res.empty = 1'b0;
                        pending_union = {pending_union, res};
                        prev = pick;
                        emitted++;
                    end
                end
                if (emitted == 0)
                begin
                    res.value = '0;
                    res.last  = 1'b1;
                    res.empty = 1'b1;
                    pending_union = {pending_union, res};
                end
                else
                    pending_union[pending_union.size() - 1].last = 1'b1;
                first_cnt  = 0;
                second_cnt = 0;
            end
            default:
            begin
            end
        endcase
    end
    endtask

    task automatic check_result();
        union_res_t want;
    begin
        if (pending_union.size() == 0)
            flag_mismatch($sformatf("unexpected transfer value_res=%0d last=%b empty_res=%b",
                                    results.value_res, results.last, results.empty_res));
        else
        begin
            want = pending_union.pop_front();
            if (results.value_res !== want.value)
                flag_mismatch($sformatf("value_res %0d, want %0d",
                                        results.value_res, want.value));
            if (results.last !== want.last)
                flag_mismatch($sformatf("last %b, want %b", results.last, want.last));
            if (results.empty_res !== want.empty)
                flag_mismatch($sformatf("empty_res %b, want %b",
                                        results.empty_res, want.empty));
        end
    end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        cmd_item_t nxt;
        if (!rst_n)
        begin
            items.valid <= 1'b0;
            items.cmd   <= sum_pkg::CMD_MERGE;
            items.value <= '0;
            send_wait   <= 0;
        end
        else
        begin
            if (items.valid && items.ready)
                apply_command(items.cmd, items.value);
            if ($urandom_range(0, 31) == 0)
                send_calm <= !send_calm;
            if (!items.valid || items.ready)
            begin
                if (send_wait > 0)
                begin
                    items.valid <= 1'b0;
                    send_wait   <= send_wait - 1;
                end
                else if (cmd_backlog.size() > 0)
                begin
                    nxt = cmd_backlog.pop_front();
                    items.valid <= 1'b1;
                    items.cmd   <= nxt.cmd;
                    items.value <= nxt.value;
                    send_wait   <= send_calm ? 0 : draw_idle();
                end
                else
                    items.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results.ready <= 1'b0;
            hold_left     <= 0;
        end
        else
        begin
            if (results.valid && results.ready)
                check_result();
            if ($urandom_range(0, 31) == 0)
                recv_calm <= !recv_calm;
            if (hold_left > 0)
            begin
                results.ready <= 1'b0;
                hold_left     <= hold_left - 1;
            end
            else
            begin
                results.ready <= 1'b1;
                hold_left     <= recv_calm ? 0 : draw_idle();
            end
        end
    end

    task automatic queue_cmd(input sum_pkg::cmd_t c, input sum_pkg::value_t v);
        cmd_item_t it;
    begin
        it.cmd   = c;
        it.value = v;
        cmd_backlog = {cmd_backlog, it};
        live_items++;
    end
    endtask

    function automatic int draw_value(input value_style_t style, input int base);
        case (style)
            STYLE_CLUSTER:
                return base + int'($urandom_range(0, 7));
            STYLE_EDGES:
            begin
                case ($urandom_range(0, 6))
                    0:       return int'(VAL_MIN);
                    1:       return int'(VAL_MIN) + 1;
                    2:       return -1;
                    3:       return 0;
                    4:       return 1;
                    5:       return int'(VAL_MAX) - 1;
                    default: return int'(VAL_MAX);
                endcase
            end
            default:
                return int'($urandom);
        endcase
    endfunction

    function automatic int draw_size();
        if ($urandom_range(0, 99) < 12)
            return $urandom_range(LIST_DEPTH - 1, LIST_DEPTH + 3);
        else
            return $urandom_range(0, 8);
    endfunction

    // one load-and-merge sequence with random content
    task automatic queue_random_set();
        int           l1[$];
        int           l2[$];
        int           n1;
        int           n2;
        int           k;
        int           base;
        value_style_t style;
    begin
        n1 = draw_size();
        n2 = draw_size();
        if ($urandom_range(0, 99) < 6)
        begin
            n1 = 0;
            n2 = 0;
        end
        case ($urandom_range(0, 2))
            0:       style = STYLE_WIDE;
            1:       style = STYLE_CLUSTER;
            default: style = STYLE_EDGES;
        endcase
        case ($urandom_range(0, 3))
            0:       base = int'(VAL_MIN);
            1:       base = int'(VAL_MAX) - 7;
            default: base = int'($urandom);
        endcase
        for (k = 0; k < n1; k++)
            l1 = {l1, draw_value(style, base)};
        for (k = 0; k < n2; k++)
            l2 = {l2, draw_value(style, base)};
        if ($urandom_range(0, 99) >= 8)
        begin
            l1.sort();
            l2.sort();
        end
        while (l1.size() > 0 || l2.size() > 0)
        begin
            if (l1.size() > 0 && (l2.size() == 0 || $urandom_range(0, 1) == 0))
                queue_cmd(sum_pkg::CMD_APPEND_FIRST, sum_pkg::value_t'(l1.pop_front()));
            else
                queue_cmd(sum_pkg::CMD_APPEND_SECOND, sum_pkg::value_t'(l2.pop_front()));
            if ($urandom_range(0, 99) < 4)
                queue_cmd(CMD_UNUSED, sum_pkg::value_t'($urandom));
        end
        queue_cmd(sum_pkg::CMD_MERGE, sum_pkg::value_t'($urandom));
    end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        items.valid   = 1'b0;
        items.cmd     = sum_pkg::CMD_MERGE;
        items.value   = '0;
        results.ready = 1'b0;

        // empty union, then an unused command
        queue_cmd(sum_pkg::CMD_MERGE, VAL_MAX);
        queue_cmd(CMD_UNUSED, VAL_MIN);
        // extremes with ties across the lists
        queue_cmd(sum_pkg::CMD_APPEND_FIRST, VAL_MIN);
        queue_cmd(sum_pkg::CMD_APPEND_SECOND, VAL_MIN);
        queue_cmd(sum_pkg::CMD_APPEND_FIRST, -32'sd1);
        queue_cmd(sum_pkg::CMD_APPEND_SECOND, 32'sd0);
        queue_cmd(sum_pkg::CMD_APPEND_FIRST, 32'sd0);
        queue_cmd(sum_pkg::CMD_APPEND_SECOND, 32'sd1);
        queue_cmd(sum_pkg::CMD_APPEND_FIRST, VAL_MAX);
        queue_cmd(sum_pkg::CMD_APPEND_SECOND, VAL_MAX);
        queue_cmd(sum_pkg::CMD_MERGE, '0);
        // one list only, each side
        queue_cmd(sum_pkg::CMD_APPEND_FIRST, 32'sd5);
        queue_cmd(sum_pkg::CMD_MERGE, VAL_MIN);
        queue_cmd(sum_pkg::CMD_APPEND_SECOND, -32'sd5);
        queue_cmd(sum_pkg::CMD_MERGE, '1);
        // unsorted load
        queue_cmd(sum_pkg::CMD_APPEND_FIRST, 32'sd3);
        queue_cmd(sum_pkg::CMD_APPEND_FIRST, 32'sd1);
        queue_cmd(sum_pkg::CMD_APPEND_SECOND, 32'sd2);
        queue_cmd(sum_pkg::CMD_MERGE, '0);

        while (live_items < RANDOM_ITEMS)
            queue_random_set();

        repeat (10) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (cmd_backlog.size() != 0 || items.valid)
            @(posedge clk);
        while (pending_union.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("sorted_union_merge verification clean");
        else
            $display("sorted_union_merge verification failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("sorted_union_merge verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sum_pkg.sv
rtl/sum_if.sv
rtl/sorted_union_merge.sv
tb/sv/sorted_union_merge_tb.sv
